### hdl/deadline_ready_queue_assert.svh
// assertion macros for the deadline ready queue
`ifndef DEADLINE_READY_QUEUE_ASSERT_SVH
`define DEADLINE_READY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRQ_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define DRQ_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define DRQ_ASSERT_IMP(label, clk, rst_n, pre, post)
`define DRQ_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

### hdl/drq_pkg.sv
package drq_pkg;
    localparam int MaxTasksDef = 8;

    localparam logic [1:0] ACT_DISPATCH = 2'd0;
    localparam logic [1:0] ACT_NEXT     = 2'd1;
    localparam logic [1:0] ACT_UPDATE   = 2'd2;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    localparam logic [2:0] RC_OK      = 3'd0;
    localparam logic [2:0] RC_FULL    = 3'd1;
    localparam logic [2:0] RC_DONE    = 3'd2;
    localparam logic [2:0] RC_EMPTY   = 3'd3;
    localparam logic [2:0] RC_BADCOND = 3'd4;
    localparam logic [2:0] RC_NONE    = 3'd5;
    localparam logic [2:0] RC_NOTFND  = 3'd6;

    localparam logic [2:0] WC_EQ    = 3'd0;
    localparam logic [2:0] WC_NE    = 3'd1;
    localparam logic [2:0] WC_GT    = 3'd2;
    localparam logic [2:0] WC_GE    = 3'd3;
    localparam logic [2:0] WC_LT    = 3'd4;
    localparam logic [2:0] WC_LE    = 3'd5;
    localparam logic [2:0] WC_NEVER = 3'd6;

    typedef struct packed {
        logic [7:0]  id;
        logic [1:0]  status;
        logic [31:0] deadline;
        logic [31:0] wait_value;
        logic [31:0] wait_mask;
        logic [2:0]  wait_cond;
        logic [31:0] watched;
    } t_entry;

    // per-cell verdict during a next scan
    typedef struct packed {
        logic stop;   // scan ends here (not blocked, condition met, or bad)
        logic met;    // blocked entry whose condition holds
        logic bad;    // invalid condition
    } t_scan;

    // signed time to deadline, ready counts as zero
    function automatic logic signed [31:0] key_of(input logic [1:0] st,
                                                  input logic [31:0] dl,
                                                  input logic [31:0] now);
        logic [31:0] d;
        d = dl - now;
        key_of = (st == ST_READY) ? 32'sd0 : $signed(d);
    endfunction
endpackage

### hdl/drq_cell.sv
// one slot of the sorted row; index 0 is the head
module drq_cell import drq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_load,       // take i_new_entry
    input  logic        i_shift_dn,   // take entry from the cell toward the head
    input  logic        i_shift_up,   // take entry from the cell toward the tail
    input  logic        i_set_run,
    input  logic        i_upd,
    input  logic [7:0]  i_upd_id,
    input  logic [31:0] i_upd_val,
    input  t_entry      i_new_entry,
    input  t_entry      i_prev,
    input  t_entry      i_next,
    output t_entry      o_entry,
    output t_scan       o_scan
);
    t_entry      r_entry;
    logic [31:0] v;
    logic        ok;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_new_entry;
        end else if (i_shift_dn) begin
            r_entry <= i_prev;
        end else if (i_shift_up) begin
            r_entry <= i_next;
        end else begin
            if (i_set_run) r_entry.status <= ST_RUNNING;
            if (i_upd && r_entry.id == i_upd_id) r_entry.watched <= i_upd_val;
        end
    end

    always_comb begin
        v  = (r_entry.wait_mask != '0) ? (r_entry.watched & r_entry.wait_mask)
                                       : r_entry.watched;
        ok = 1'b0;
        o_scan.bad = 1'b0;
        case (r_entry.wait_cond)
            WC_EQ:    ok = (v == r_entry.wait_value);
            WC_NE:    ok = (v != r_entry.wait_value);
            WC_GT:    ok = (v >  r_entry.wait_value);
            WC_GE:    ok = (v >= r_entry.wait_value);
            WC_LT:    ok = (v <  r_entry.wait_value);
            WC_LE:    ok = (v <= r_entry.wait_value);
            WC_NEVER: ok = 1'b0;
            default:  o_scan.bad = 1'b1;
        endcase
        if (r_entry.status != ST_BLOCKED) begin
            o_scan.stop = 1'b1;
            o_scan.met  = 1'b0;
            o_scan.bad  = 1'b0;
        end else begin
            o_scan.met  = ok && !o_scan.bad;
            o_scan.stop = ok || o_scan.bad;
        end
    end

    assign o_entry = r_entry;
endmodule

### hdl/deadline_ready_queue.sv
// channel   | direction | handshake            | payload
// request   | in        | i_start & !o_busy    | i_action .. i_watched_value
// result    | out       | o_done, one cycle    | o_result_code .. o_entry_count
// a rejection or an update is answered without leaving idle; dispatch walks
// the row from the tail one cell a cycle, next walks it from the head one cell a cycle
// the row itself is sorted with the head at cell 0, so no ring pointers exist
// synchronous active-low reset empties the queue; cell contents are not cleared
// the receiver cannot stall: o_done is high for one cycle per request
module deadline_ready_queue import drq_pkg::*; #(
    parameter int MAX_TASKS = MaxTasksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_task_id,
    input  logic [1:0]  i_task_status,
    input  logic [31:0] i_deadline,
    input  logic [31:0] i_now_ticks,
    input  logic [31:0] i_wait_value,
    input  logic [31:0] i_wait_mask,
    input  logic [2:0]  i_wait_condition,
    input  logic [31:0] i_watched_value,
    output logic        o_done,
    output logic [2:0]  o_result_code,
    output logic [7:0]  o_selected_id,
    output logic        o_run_selected,
    output logic [3:0]  o_entry_count
);
`include "deadline_ready_queue_assert.svh"
    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_POP  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_pos, n_pos;
    logic [31:0]   r_now;
    t_entry        r_new;
    logic          r_done;
    logic [2:0]    r_code;
    logic [7:0]    r_sel;
    logic          r_run;

    t_entry cell_q [MAX_TASKS];
    t_scan  scan   [MAX_TASKS];
    logic [MAX_TASKS-1:0] ld, sdn, sup, srun;
    logic upd;

    logic accept;
    assign accept = i_start && (r_state == S_IDLE);

    // insertion compare on the cell just ahead of the hole
    logic [IW-1:0] prev_pos;
    logic          move_on;
    assign prev_pos = r_pos - IW'(1);
    assign move_on  = (r_pos != '0) &&
        (key_of(cell_q[prev_pos].status, cell_q[prev_pos].deadline, r_now) >
         key_of(r_new.status, r_new.deadline, r_now));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        ld = '0; sdn = '0; sup = '0; srun = '0;
        upd = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos = '0;
                    case (i_action)
                        ACT_DISPATCH: begin
                            if (i_task_status != ST_DONE && r_count != FULL) begin
                                n_state = S_INS;
                                n_pos   = IW'(r_count);
                            end
                        end
                        ACT_NEXT: if (r_count != '0) n_state = S_SCAN;
                        ACT_UPDATE: upd = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                if (move_on) begin
                    sdn[r_pos] = 1'b1;
                    n_pos = prev_pos;
                end else begin
                    ld[r_pos] = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan[r_pos].bad) begin
                    n_state = S_IDLE;
                end else if (scan[r_pos].stop || CW'(r_pos) == r_count - CW'(1)) begin
                    srun[r_pos] = scan[r_pos].met;
                    n_state = S_POP;
                end else begin
                    n_pos = r_pos + IW'(1);
                end
            end
            default: begin
                // taken entry leaves: cells behind it move toward the head
                for (int k = 0; k < MAX_TASKS - 1; k++)
                    if (IW'(k) >= r_pos) sup[k] = 1'b1;
                n_count = r_count - CW'(1);
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (accept && n_state == S_IDLE) || (r_state == S_INS && !move_on)
                    || (r_state == S_SCAN && n_state == S_IDLE) || (r_state == S_POP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (accept) begin
            r_now <= i_now_ticks;
            r_new <= '{id: i_task_id, status: i_task_status, deadline: i_deadline,
                       wait_value: i_wait_value, wait_mask: i_wait_mask,
                       wait_cond: i_wait_condition, watched: i_watched_value};
            r_sel  <= '0;
            r_run  <= 1'b0;
            r_code <= RC_OK;
            case (i_action)
                ACT_DISPATCH: begin
                    if (i_task_status == ST_DONE) r_code <= RC_DONE;
                    else if (r_count == FULL)     r_code <= RC_FULL;
                end
                ACT_NEXT: if (r_count == '0) r_code <= RC_EMPTY;
                ACT_UPDATE: begin
                    r_code <= RC_NOTFND;
                    for (int k = 0; k < MAX_TASKS; k++)
                        if (CW'(k) < r_count && cell_q[k].id == i_task_id)
                            r_code <= RC_OK;
                end
                default: ;
            endcase
        end else if (r_state == S_SCAN && n_state != S_SCAN) begin
            r_sel <= cell_q[r_pos].id;
            if (scan[r_pos].bad)       r_code <= RC_BADCOND;
            else if (scan[r_pos].stop) r_run  <= 1'b1;
            else                       r_code <= RC_NONE;
        end
    end

    // scanned entry is taken out in place; the cells behind it move toward the head
    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            t_entry prev_e, next_e;
            assign prev_e = (g == 0) ? cell_q[0] : cell_q[(g == 0) ? 0 : g - 1];
            assign next_e = (g == MAX_TASKS - 1) ? cell_q[g]
                                                 : cell_q[(g == MAX_TASKS - 1) ? g : g + 1];
            drq_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (ld[g]),
                .i_shift_dn  (sdn[g]),
                .i_shift_up  (sup[g]),
                .i_set_run   (srun[g]),
                .i_upd       (upd && CW'(g) < r_count),
                .i_upd_id    (i_task_id),
                .i_upd_val   (i_watched_value),
                .i_new_entry (r_new),
                .i_prev      (prev_e),
                .i_next      (next_e),
                .o_entry     (cell_q[g]),
                .o_scan      (scan[g])
            );
        end
    endgenerate

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_code  = r_code;
    assign o_selected_id  = r_sel;
    assign o_run_selected = r_run;
    assign o_entry_count  = 4'(r_count);

    `DRQ_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `DRQ_ASSERT_NXT(a_ins_grows, i_clk, i_rst_n, r_state == S_INS && !move_on, r_count == $past(r_count) + CW'(1))
    `DRQ_ASSERT_NXT(a_pop_ends, i_clk, i_rst_n, r_state == S_POP, r_done && r_state == S_IDLE)
    `DRQ_ASSERT_IMP(a_run_ok, i_clk, i_rst_n, r_done && r_run, r_code == RC_OK)
endmodule
